// ===== hw/rtl/tvp_pkg.sv =====
// Package for the trapezoidal velocity profile block: constants, codes, types.
// Used by tvp_alu and trapezoidal_velocity_profile; depends on nothing.
package tvp_pkg;

    localparam int AXES           = 6;
    localparam int FIRST_ROT_AXIS = 3;
    localparam int HOME_AXIS      = 2;
    localparam int AXIS_IDX_W     = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic [30:0] ACCEL_RESET = 31'd32768;
    localparam logic [30:0] SPEED_RESET = 31'd6554;
    localparam logic [31:0] HOME_RESET  = 32'd179136;

    // moves with |diff| * 100 < 65536 are treated as zero
    localparam logic [32:0] SMALL_LIMIT = 33'd656;

    // step = round(mag / 250) = floor(((mag + 125) >> 1) / 125); the divide by 125 is a
    // multiply by ceil(2^37 / 125) and a 37-bit right shift, exact for operands below 2^32
    localparam logic [32:0] STEP_BIAS  = 33'd125;
    localparam logic [32:0] STEP_RECIP = 33'd1099511628;

    localparam logic [5:0] MUL_STEPS  = 6'd33;
    localparam logic [5:0] DIV_STEPS  = 6'd49;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    // configuration register indexes
    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_HOME  = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] x;
        logic [32:0] y;
    } alu_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] res;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VV,
        ST_AM,
        ST_SQRT,
        ST_T1,
        ST_T2,
        ST_EVAL,
        ST_RAMP,
        ST_STEP,
        ST_UPD,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/trapezoidal_velocity_profile.sv =====
// Top level of the trapezoidal velocity profile block: sequencer and axis targets.
// Depends on tvp_pkg and tvp_alu.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_ready, axis, start_pos,      | beat in
//          | goal_pos, elapsed                        |
//  out     | out_valid/out_ready, velocity,           | beat out
//          | target_pos, axis_out                     |
//  cfg     | cfg_we, cfg_index, cfg_data              | write only
//
// One beat at a time. A point on a ramp runs two multiplies, then a square root and a
// divide for a triangle or two divides for a trapezoid, then the ramp multiply and the
// step multiply; in cruise or after the stop the ramp multiply is skipped, a tiny move
// goes straight to the target update and a bad axis straight to the output.
// in_ready is high only in idle; the result is held until out_ready, idle follows.
// Reset clears the sequencer and the axis targets (axis 2 takes HOME_RESET).
module trapezoidal_velocity_profile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  axis,
    input  logic [31:0] start_pos,
    input  logic [31:0] goal_pos,
    input  logic [31:0] elapsed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] velocity,
    output logic [31:0] target_pos,
    output logic [2:0]  axis_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tvp_pkg::*;

    state_t state_reg;
    state_t state_next;

    alu_req_t req;
    alu_rsp_t rsp;

    logic [30:0] accel_reg;
    logic [30:0] speed_reg;
    logic [31:0] targets_reg [AXES];

    logic [2:0]  axis_reg;
    logic [30:0] a_reg;
    logic [30:0] v_reg;
    logic [32:0] m_reg;
    logic        neg_reg;
    logic        tri_reg;
    logic        down_reg;
    logic [31:0] t_reg;
    logic [31:0] ty_reg;
    logic [63:0] vv_reg;
    logic [63:0] am_reg;
    logic [31:0] peak_reg;
    logic [48:0] t1_reg;
    logic [48:0] t2_reg;
    logic [49:0] tf_reg;
    logic [31:0] mag_reg;
    logic [31:0] delta_reg;
    logic [31:0] vel_reg;
    logic [31:0] tgt_reg;

    logic [32:0] diff;
    logic [32:0] mag_in;
    logic        rot_in;
    logic [30:0] a_sh;
    logic [30:0] v_sh;
    logic        accept;
    logic        in_range;
    logic        alu_state;
    logic [46:0] prod;
    logic [32:0] step_sum;
    logic [AXIS_IDX_W-1:0] idx;
    logic [31:0] cur_tgt;
    logic [32:0] sdelta;
    logic [32:0] sum;
    logic [31:0] sat;

    assign accept   = in_valid && in_ready;
    assign diff     = {goal_pos[31], goal_pos} - {start_pos[31], start_pos};
    assign mag_in   = diff[32] ? (33'd0 - diff) : diff;
    assign rot_in   = (axis >= 3'(FIRST_ROT_AXIS));
    assign a_sh     = rot_in ? {1'b0, accel_reg[30:1]} : accel_reg;
    assign v_sh     = rot_in ? {1'b0, speed_reg[30:1]} : speed_reg;
    assign in_range = ({1'b0, axis} < 4'(AXES));
    assign prod     = rsp.res[62:16];
    assign step_sum = {1'b0, mag_reg} + STEP_BIAS;
    assign idx      = axis_reg[AXIS_IDX_W-1:0];
    assign cur_tgt  = targets_reg[idx];

    // saturating target update
    always_comb
    begin
        sdelta = neg_reg ? (33'd0 - {1'b0, delta_reg}) : {1'b0, delta_reg};
        sum    = {cur_tgt[31], cur_tgt} + sdelta;
        if (sum[32] != sum[31])
            sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            sat = sum[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                        state_next = ST_OUT;
                    else if (mag_in < SMALL_LIMIT)
                        state_next = ST_UPD;
                    else
                        state_next = ST_VV;
                end
            end
            ST_VV:   if (rsp.done) state_next = ST_AM;
            ST_AM:   if (rsp.done) state_next = (vv_reg > rsp.res) ? ST_SQRT : ST_T1;
            ST_SQRT: if (rsp.done) state_next = ST_T1;
            ST_T1:   if (rsp.done) state_next = tri_reg ? ST_EVAL : ST_T2;
            ST_T2:   if (rsp.done) state_next = ST_EVAL;
            ST_EVAL:
            begin
                if ({17'd0, t_reg} < t1_reg)
                    state_next = ST_RAMP;
                else if ({17'd0, t_reg} <= t2_reg)
                    state_next = ST_STEP;
                else if ({18'd0, t_reg} <= tf_reg)
                    state_next = ST_RAMP;
                else
                    state_next = ST_STEP;
            end
            ST_RAMP: if (rsp.done) state_next = ST_STEP;
            ST_STEP: if (rsp.done) state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and unit requests
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        alu_state = 1'b0;
        req.op    = OP_MUL;
        req.x     = 64'd0;
        req.y     = 33'd0;
        case (state_reg)
            ST_VV:
            begin
                alu_state = 1'b1;
                req.x     = {33'd0, v_reg};
                req.y     = {2'd0, v_reg};
            end
            ST_AM:
            begin
                alu_state = 1'b1;
                req.x     = {33'd0, a_reg};
                req.y     = m_reg;
            end
            ST_SQRT:
            begin
                alu_state = 1'b1;
                req.op    = OP_SQRT;
                req.x     = am_reg;
            end
            ST_T1:
            begin
                alu_state = 1'b1;
                req.op    = OP_DIV;
                req.x     = {16'd0, peak_reg, 16'd0};
                req.y     = {2'd0, a_reg};
            end
            ST_T2:
            begin
                alu_state = 1'b1;
                req.op    = OP_DIV;
                req.x     = {15'd0, m_reg, 16'd0};
                req.y     = {2'd0, v_reg};
            end
            ST_RAMP:
            begin
                alu_state = 1'b1;
                req.x     = {33'd0, a_reg};
                req.y     = {1'b0, ty_reg};
            end
            ST_STEP:
            begin
                // rounded velocity / 250 by reciprocal multiply
                alu_state = 1'b1;
                req.x     = {32'd0, step_sum[32:1]};
                req.y     = STEP_RECIP;
            end
            default:
            begin
                alu_state = 1'b0;
            end
        endcase
        req.start = alu_state && !rsp.busy && !rsp.done;
    end

    tvp_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers and axis targets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_RESET;
            speed_reg <= SPEED_RESET;
            for (int i = 0; i < AXES; i++)
                targets_reg[i] <= (i == HOME_AXIS) ? HOME_RESET : 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACCEL: accel_reg <= cfg_data[30:0];
                    REG_SPEED: speed_reg <= cfg_data[30:0];
                    REG_HOME:
                    begin
                        if (HOME_AXIS < AXES)
                            targets_reg[HOME_AXIS] <= cfg_data;
                    end
                    default:   accel_reg <= accel_reg;
                endcase
            end
            if (state_reg == ST_UPD)
                targets_reg[idx] <= sat;
        end
    end

    // per-beat datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    axis_reg  <= axis;
                    t_reg     <= elapsed;
                    a_reg     <= (a_sh == 31'd0) ? 31'd1 : a_sh;
                    v_reg     <= (v_sh == 31'd0) ? 31'd1 : v_sh;
                    m_reg     <= mag_in;
                    neg_reg   <= diff[32];
                    mag_reg   <= 32'd0;
                    delta_reg <= 32'd0;
                    vel_reg   <= 32'd0;
                    tgt_reg   <= 32'd0;
                end
            end
            ST_VV:
            begin
                if (rsp.done)
                    vv_reg <= rsp.res;
            end
            ST_AM:
            begin
                if (rsp.done)
                begin
                    am_reg   <= rsp.res;
                    tri_reg  <= (vv_reg > rsp.res);
                    peak_reg <= {1'b0, v_reg};
                end
            end
            ST_SQRT:
            begin
                if (rsp.done)
                    peak_reg <= rsp.res[31:0];
            end
            ST_T1:
            begin
                if (rsp.done)
                begin
                    t1_reg <= rsp.res[48:0];
                    t2_reg <= rsp.res[48:0];
                    tf_reg <= {rsp.res[48:0], 1'b0};
                end
            end
            ST_T2:
            begin
                if (rsp.done)
                begin
                    t2_reg <= rsp.res[48:0];
                    tf_reg <= {1'b0, t1_reg} + {1'b0, rsp.res[48:0]};
                end
            end
            ST_EVAL:
            begin
                // pick ramp-up, cruise, ramp-down or stopped
                if ({17'd0, t_reg} < t1_reg)
                begin
                    down_reg <= 1'b0;
                    ty_reg   <= t_reg;
                end
                else if ({17'd0, t_reg} <= t2_reg)
                    mag_reg <= peak_reg;
                else if ({18'd0, t_reg} <= tf_reg)
                begin
                    down_reg <= 1'b1;
                    ty_reg   <= t_reg - t2_reg[31:0];
                end
                else
                    mag_reg <= 32'd0;
            end
            ST_RAMP:
            begin
                if (rsp.done)
                begin
                    if (!down_reg)
                        mag_reg <= prod[31:0];
                    else if (prod >= {15'd0, peak_reg})
                        mag_reg <= 32'd0;
                    else
                        mag_reg <= peak_reg - prod[31:0];
                end
            end
            ST_STEP:
            begin
                // product >> 37 is the step
                if (rsp.done)
                    delta_reg <= {5'd0, rsp.res[63:37]};
            end
            ST_UPD:
            begin
                vel_reg <= neg_reg ? (32'd0 - mag_reg) : mag_reg;
                tgt_reg <= sat;
            end
            default:
            begin
                vel_reg <= vel_reg;
            end
        endcase
    end

    assign velocity   = vel_reg;
    assign target_pos = tgt_reg;
    assign axis_out   = axis_reg;

endmodule

// ===== hw/rtl/tvp_alu.sv =====
// Shared iterative unit: shift-add multiply, restoring divide, restoring sqrt.
// One result bit per cycle. Depends on tvp_pkg.
module tvp_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  tvp_pkg::alu_req_t req,
    output tvp_pkg::alu_rsp_t rsp
);
    import tvp_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    alu_op_t     op_reg;
    logic [63:0] acc_reg;
    logic [63:0] xr_reg;
    logic [32:0] yr_reg;
    logic [31:0] root_reg;

    logic [63:0] acc_next;
    logic [63:0] xr_next;
    logic [32:0] yr_next;
    logic [31:0] root_next;
    logic [5:0]  steps;

    logic [33:0] div_sh;
    logic [34:0] sq_sh;
    logic [34:0] sq_trial;

    // one step of the selected operation
    always_comb
    begin
        acc_next  = acc_reg;
        xr_next   = xr_reg;
        yr_next   = yr_reg;
        root_next = root_reg;
        div_sh    = {acc_reg[32:0], xr_reg[48]};
        sq_sh     = {acc_reg[32:0], xr_reg[63:62]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        case (op_reg)
            OP_MUL:
            begin
                acc_next = {acc_reg[62:0], 1'b0} + (yr_reg[32] ? xr_reg : 64'd0);
                yr_next  = {yr_reg[31:0], 1'b0};
            end
            OP_DIV:
            begin
                if (div_sh >= {1'b0, yr_reg})
                begin
                    acc_next = {30'd0, div_sh - {1'b0, yr_reg}};
                    xr_next  = {xr_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = {30'd0, div_sh};
                    xr_next  = {xr_reg[62:0], 1'b0};
                end
            end
            OP_SQRT:
            begin
                xr_next = {xr_reg[61:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    acc_next  = {29'd0, sq_sh - sq_trial};
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next  = {29'd0, sq_sh};
                    root_next = {root_reg[30:0], 1'b0};
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        case (req.op)
            OP_MUL:  steps = MUL_STEPS;
            OP_DIV:  steps = DIV_STEPS;
            OP_SQRT: steps = SQRT_STEPS;
            default: steps = MUL_STEPS;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg   <= req.op;
            acc_reg  <= 64'd0;
            root_reg <= 32'd0;
            xr_reg   <= req.x;
            yr_reg   <= req.y;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            xr_reg   <= xr_next;
            yr_reg   <= yr_next;
            root_reg <= root_next;
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        case (op_reg)
            OP_MUL:  rsp.res = acc_reg;
            OP_DIV:  rsp.res = {15'd0, xr_reg[48:0]};
            OP_SQRT: rsp.res = {32'd0, root_reg};
            default: rsp.res = acc_reg;
        endcase
    end

endmodule

// ===== tb/trapezoidal_velocity_profile_tb.sv =====
// Self-checking bench for trapezoidal_velocity_profile: a directed table, then random
// profiles over several register settings, each beat checked against a local model or
// its typed table row. Depends on tvp_pkg and the trapezoidal_velocity_profile RTL.
module trapezoidal_velocity_profile_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvp_pkg::*;

    localparam int         CYCLE_LIMIT  = 3000000;
    localparam int         PHASE_BEATS  = 340;
    localparam int         DRAIN_CYCLES = 300;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  axis;
    logic [31:0] start_pos;
    logic [31:0] goal_pos;
    logic [31:0] elapsed;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] velocity;
    logic [31:0] target_pos;
    logic [2:0]  axis_out;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    typedef struct {
        logic [31:0] vel;
        logic [31:0] tgt;
        logic [2:0]  ax;
    } motion_t;

    typedef struct {
        logic [2:0]  ax;
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] t;
        logic        typed;
        logic [31:0] vel;
        logic [31:0] tgt;
    } row_t;

    // model copy of registers and per-axis targets
    logic [30:0]        accel_m;
    logic [30:0]        speed_m;
    logic signed [31:0] targets_m [AXES];

    motion_t pending_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      beats_sent;
    int      beats_seen = 0;
    logic    idle_on;

    trapezoidal_velocity_profile DUT (.*);

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (beat %0d)", what, got, want, beats_seen);
    endtask

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // profile velocity and target update for one beat; advances model state
    function automatic motion_t plan_motion(input logic [2:0] ax, input logic [31:0] p0,
                                            input logic [31:0] p1, input logic [31:0] t);
        motion_t            o;
        logic [63:0]        a, v, m, pk, t1, t2, tf, mag, dec, tt;
        logic signed [33:0] diff;
        logic signed [63:0] vel, dlt, nxt;
        o.ax = ax;
        if (ax >= AXES)
        begin
            o.vel = '0;
            o.tgt = '0;
            return o;
        end
        a = 64'(accel_m);
        v = 64'(speed_m);
        if (ax >= FIRST_ROT_AXIS)
        begin
            a >>= 1;
            v >>= 1;
        end
        if (a == 0) a = 1;
        if (v == 0) v = 1;
        tt = 64'(t);
        diff = $signed({{2{p1[31]}}, p1}) - $signed({{2{p0[31]}}, p0});
        m = diff[33] ? 64'(-diff) : 64'(diff);
        if (m * 100 < 65536) m = 0;
        mag = 0;
        if (m != 0)
        begin
            if (v * v > a * m)
            begin
                pk = root64(a * m);
                t1 = (pk << 16) / a;
                t2 = t1;
                tf = t1 * 2;
            end
            else
            begin
                pk = v;
                t1 = (v << 16) / a;
                t2 = (m << 16) / v;
                tf = t1 + t2;
            end
            if (tt < t1)
                mag = (a * tt) >> 16;
            else if (tt <= t2)
                mag = pk;
            else if (tt <= tf)
            begin
                dec = (a * (tt - t2)) >> 16;
                mag = (dec >= pk) ? 0 : pk - dec;
            end
        end
        vel = $signed(mag);
        dlt = $signed((mag * 2 + 250) / 500);
        if (diff < 0)
        begin
            vel = -vel;
            dlt = -dlt;
        end
        nxt = 64'(targets_m[ax]) + dlt;
        if (nxt > 64'sh7FFFFFFF) nxt = 64'sh7FFFFFFF;
        if (nxt < -64'sh80000000) nxt = -64'sh80000000;
        targets_m[ax] = nxt[31:0];
        o.vel = vel[31:0];
        o.tgt = nxt[31:0];
        return o;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            motion_t w;
            beats_seen++;
            if (pending_q.size() == 0)
                report("unexpected beat, axis", 32'(axis_out), 32'd0);
            else
            begin
                w = pending_q.pop_front();
                if (velocity !== w.vel) report("velocity", velocity, w.vel);
                if (target_pos !== w.tgt) report("target_pos", target_pos, w.tgt);
                if (axis_out !== w.ax) report("axis_out", 32'(axis_out), 32'(w.ax));
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [2:0] ax, input logic [31:0] p0,
                             input logic [31:0] p1, input logic [31:0] t,
                             input logic typed, input logic [31:0] ev, input logic [31:0] et);
        motion_t w;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        axis      <= ax;
        start_pos <= p0;
        goal_pos  <= p1;
        elapsed   <= t;
        #1;
        while (!in_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        w = plan_motion(ax, p0, p1, t);
        if (typed)
        begin
            w.vel = ev;
            w.tgt = et;
        end
        pending_q = {pending_q, w};
        beats_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ACCEL)
            accel_m = data[30:0];
        else if (idx == REG_SPEED)
            speed_m = data[30:0];
        else if (idx == REG_HOME)
        begin
            if (HOME_AXIS < AXES) targets_m[HOME_AXIS] = data;
        end
    endtask

    task automatic random_beat();
        logic [2:0]  ax;
        logic [31:0] p0, p1, t, d;
        ax = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        p0 = $urandom;
        case ($urandom_range(0, 3))
            0: d = $urandom;
            1: d = 32'($signed($urandom_range(0, 2000)) - 1000);
            default: d = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1)) d = -d;
        p1 = p0 + d;
        t = ($urandom_range(0, 4) == 0) ? $urandom : ($urandom >> $urandom_range(0, 31));
        send_beat(ax, p0, p1, t, 1'b0, '0, '0);
    endtask

    row_t plan_rows[] = '{
        '{3'd0, 32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0},                      // zero move
        '{3'd6, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0}, // bad axis
        '{3'd7, 32'd0, 32'd65536, 32'd100, 1'b1, 32'd0, 32'd0},                // bad axis
        '{3'd0, 32'd0, 32'd655, 32'd100, 1'b1, 32'd0, 32'd0},                  // below 0.01
        '{3'd1, 32'd0, 32'd656, 32'd100, 1'b0, 32'd0, 32'd0},                  // just above
        '{3'd0, 32'd0, 32'h7FFFFFFF, 32'h8000, 1'b0, 32'd0, 32'd0},
        '{3'd1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0},
        '{3'd1, 32'h7FFFFFFF, 32'h80000000, 32'd300000, 1'b0, 32'd0, 32'd0},
        '{3'd0, 32'd0, 32'd1000, 32'd50, 1'b0, 32'd0, 32'd0},                  // triangle
        '{3'd0, 32'd0, 32'd1000, 32'd3000, 1'b0, 32'd0, 32'd0},
        '{3'd0, 32'd0, 32'd65536, 32'd662000, 1'b0, 32'd0, 32'd0},             // ramp down
        '{3'd3, 32'd0, 32'd65536, 32'd13107, 1'b0, 32'd0, 32'd0},              // rotational
        '{3'd4, 32'd65536, 32'd0, 32'd200000, 1'b0, 32'd0, 32'd0},
        '{3'd5, 32'hFFFF0000, 32'd131072, 32'd40000, 1'b0, 32'd0, 32'd0},
        '{3'd2, 32'd0, 32'd65536, 32'd20000, 1'b0, 32'd0, 32'd0},              // home axis
        '{3'd2, 32'd0, 32'hFFFF0000, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0}
    };

    // register settings per phase: accel, top speed, home height
    logic [31:0] phase_regs [5][3] = '{
        '{32'd32768, 32'd6554, 32'd179136},
        '{32'd1, 32'd1, 32'h80000000},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFF00},
        '{32'd0, 32'd0, 32'h80000100},
        '{32'd65536, 32'h7FFFFFFF, 32'd0}
    };

    // main sequence
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        axis       = '0;
        start_pos  = '0;
        goal_pos   = '0;
        elapsed    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        beats_sent = 0;
        idle_on    = 1'b1;
        accel_m    = ACCEL_RESET;
        speed_m    = SPEED_RESET;
        foreach (targets_m[i]) targets_m[i] = '0;
        if (HOME_AXIS < AXES) targets_m[HOME_AXIS] = HOME_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan_rows[i])
            send_beat(plan_rows[i].ax, plan_rows[i].p0, plan_rows[i].p1, plan_rows[i].t,
                      plan_rows[i].typed, plan_rows[i].vel, plan_rows[i].tgt);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            write_reg(REG_ACCEL, ph == 3 ? 32'($urandom_range(0, 3)) : phase_regs[ph][0]);
            write_reg(REG_SPEED, ph == 3 ? 32'($urandom_range(0, 3)) : phase_regs[ph][1]);
            write_reg(REG_HOME, phase_regs[ph][2]);
            write_reg(REG_SPARE, $urandom);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (ph == 4 && n > PHASE_BEATS / 2) idle_on = 1'b0;
                random_beat();
            end
        end
        wait_drained();
        // one phase with random register values
        write_reg(REG_ACCEL, $urandom);
        write_reg(REG_SPEED, $urandom);
        write_reg(REG_HOME, $urandom);
        repeat (60) random_beat();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        errors += pending_q.size();

        $display("sent %0d beats, checked %0d results, %0d mismatches", beats_sent,
                 beats_seen, errors);
        $display("covered 6 register settings incl. extremes, linear/rotational/bad axes");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
